>>> hw/rtl/srp_pkg.sv
// Shared types and constants for the sensor report retry and pairing core.
`timescale 1ns / 1ps
package srp_pkg;

   // Packet operation bytes
   localparam logic [7:0] OP_DATA       = 8'h00;
   localparam logic [7:0] OP_PAIR       = 8'h01;
   localparam logic [7:0] OP_DATA_REPLY = 8'h80;
   localparam logic [7:0] OP_PAIR_REPLY = 8'h81;

   // Register reset values
   localparam logic [7:0] RESET_TIMEOUT   = 8'd100;
   localparam logic [3:0] RESET_MAX_SENDS = 4'd5;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 8;

   typedef enum logic [1:0] {
      CMD_TICK  = 2'd0,
      CMD_START = 2'd1,
      CMD_RX    = 2'd2,
      CMD_NONE  = 2'd3
   } cmd_type;

   typedef enum logic [CSR_ADDR_W-1:0] {
      REG_SENSOR_ID     = 3'd0,
      REG_BASE_ID       = 3'd1,
      REG_PROGRAMMED    = 3'd2,
      REG_PAIRING_MODE  = 3'd3,
      REG_TIMEOUT_TICKS = 3'd4,
      REG_MAX_SENDS     = 3'd5
   } reg_idx_type;

   typedef struct packed {
      logic        tx_valid;
      logic [7:0]  tx_dest;
      logic [7:0]  tx_src;
      logic [7:0]  tx_op;
      logic [23:0] tx_temp;
      logic [23:0] tx_batt;
      logic        go_sleep;
      logic        paired;
      logic [7:0]  learned_base;
   } rsp_type;

endpackage

>>> hw/rtl/srp_channels.sv
// Handshake channel interfaces: request, response and register write.
`timescale 1ns / 1ps
interface srp_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  command;
   logic [7:0]  rx_first;
   logic [7:0]  rx_second;
   logic [7:0]  rx_op;
   logic [23:0] temp_word;
   logic [23:0] batt_word;
   modport source (output valid, command, rx_first, rx_second, rx_op, temp_word, batt_word,
                   input ready);
   modport sink   (input valid, command, rx_first, rx_second, rx_op, temp_word, batt_word,
                   output ready);
endinterface

interface srp_rsp_if;
   logic        valid;
   logic        ready;
   logic        tx_valid;
   logic [7:0]  tx_dest;
   logic [7:0]  tx_src;
   logic [7:0]  tx_op;
   logic [23:0] tx_temp;
   logic [23:0] tx_batt;
   logic        go_sleep;
   logic        paired;
   logic [7:0]  learned_base;
   modport source (output valid, tx_valid, tx_dest, tx_src, tx_op, tx_temp, tx_batt,
                   go_sleep, paired, learned_base, input ready);
   modport sink   (input valid, tx_valid, tx_dest, tx_src, tx_op, tx_temp, tx_batt,
                   go_sleep, paired, learned_base, output ready);
endinterface

interface srp_csr_if;
   logic       valid;
   logic       ready;
   logic [2:0] index;
   logic [7:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

>>> hw/rtl/sensor_report_retry_and_pairing_core.sv
// Top level: sender-side report retry and pairing control.
`timescale 1ns / 1ps
// Usage
//  req_bus : one item per command (tick, start of a report, received header).
//            A start carries temperature and battery words, which are held.
//  rsp_bus : exactly one result item per request item, in order.
//  csr_bus : register writes, always ready; write only while the core is idle.
// Latency: a result is valid the cycle after its request is accepted.
// Throughput: one item per cycle while results are taken. All decisions
//  (timer compare, send-count compare, header match) are single-level compare
//  logic between the request and the response register, which sets the pace.
// Stall: req_bus.ready = !rsp valid || rsp_bus.ready, so the core keeps taking
//  items while the pending result is being taken; it stops only while the
//  response register holds an item the receiver has not accepted.
// Reset (synchronous, active high): registers return to their defaults
//  (timeout 100 ticks, 5 sends), reply timer stopped, count and held
//  readings zero, response register empty.
module sensor_report_retry_and_pairing_core (
   input  logic clock,
   input  logic reset,
   srp_req_if.sink   req_bus,
   srp_rsp_if.source rsp_bus,
   srp_csr_if.sink   csr_bus
);
   import srp_pkg::*;

   // configuration
   logic [7:0]  sensor_id_ff, base_id_ff, timeout_ff;
   logic        programmed_ff, pairing_mode_ff;
   logic [3:0]  max_sends_ff;
   // exchange state
   logic [7:0]  timer_ff, timer_in;
   logic [3:0]  count_ff, count_in;
   logic [23:0] temp_ff, temp_in, batt_ff, batt_in;
   logic [7:0]  base_in;
   logic        prog_in;
   // response register
   logic        rsp_valid_ff;
   rsp_type     rsp_ff, rsp_in;

   logic        req_fire, csr_fire, attempt;
   logic [3:0]  count_cur;
   cmd_type     cmd;

   assign req_bus.ready = !rsp_valid_ff || rsp_bus.ready;
   assign req_fire      = req_bus.valid && req_bus.ready;
   assign csr_bus.ready = 1'b1;
   assign csr_fire      = csr_bus.valid;
   assign cmd           = cmd_type'(req_bus.command);

   always_comb begin
      timer_in  = timer_ff;
      count_in  = count_ff;
      temp_in   = temp_ff;
      batt_in   = batt_ff;
      base_in   = base_id_ff;
      prog_in   = programmed_ff;
      rsp_in    = '0;
      attempt   = 1'b0;
      count_cur = count_ff;

      case (cmd)
         CMD_TICK: begin
            if (timer_ff != 8'd0) begin
               timer_in = timer_ff - 8'd1;
               attempt  = (timer_ff == 8'd1);
            end
         end
         CMD_START: begin
            temp_in   = req_bus.temp_word;
            batt_in   = req_bus.batt_word;
            count_cur = 4'd0;
            count_in  = 4'd0;
            attempt   = 1'b1;
         end
         CMD_RX: begin
            if (pairing_mode_ff) begin
               if (req_bus.rx_first == 8'd0 && req_bus.rx_op == OP_PAIR) begin
                  base_in             = req_bus.rx_second;
                  prog_in             = 1'b1;
                  rsp_in.tx_valid     = 1'b1;
                  rsp_in.tx_dest      = req_bus.rx_second;
                  rsp_in.tx_src       = sensor_id_ff;
                  rsp_in.tx_op        = OP_PAIR_REPLY;
                  rsp_in.paired       = 1'b1;
                  rsp_in.learned_base = req_bus.rx_second;
                  attempt             = 1'b1;
               end
            end else if (req_bus.rx_first == sensor_id_ff &&
                         req_bus.rx_second == base_id_ff &&
                         req_bus.rx_op == OP_DATA_REPLY) begin
               timer_in        = 8'd0;
               count_in        = 4'd0;
               rsp_in.go_sleep = 1'b1;
            end
         end
         default: begin
         end
      endcase

      // send attempt: start, timeout, or accepted pairing
      if (attempt) begin
         if (pairing_mode_ff) begin
            count_in = 4'd0;
            timer_in = timeout_ff;
         end else if (count_cur < max_sends_ff) begin
            if (programmed_ff) begin
               rsp_in.tx_valid = 1'b1;
               rsp_in.tx_dest  = base_id_ff;
               rsp_in.tx_src   = sensor_id_ff;
               rsp_in.tx_op    = OP_DATA;
               rsp_in.tx_temp  = temp_in;
               rsp_in.tx_batt  = batt_in;
               count_in        = count_cur + 4'd1;
            end
            timer_in = timeout_ff;
         end else begin
            rsp_in.go_sleep = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sensor_id_ff    <= 8'd0;
         base_id_ff      <= 8'd0;
         programmed_ff   <= 1'b0;
         pairing_mode_ff <= 1'b0;
         timeout_ff      <= RESET_TIMEOUT;
         max_sends_ff    <= RESET_MAX_SENDS;
         timer_ff        <= 8'd0;
         count_ff        <= 4'd0;
         temp_ff         <= 24'd0;
         batt_ff         <= 24'd0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (req_fire) begin
            timer_ff      <= timer_in;
            count_ff      <= count_in;
            temp_ff       <= temp_in;
            batt_ff       <= batt_in;
            base_id_ff    <= base_in;
            programmed_ff <= prog_in;
         end
         if (csr_fire) begin
            case (reg_idx_type'(csr_bus.index))
               REG_SENSOR_ID:     sensor_id_ff    <= csr_bus.data;
               REG_BASE_ID:       base_id_ff      <= csr_bus.data;
               REG_PROGRAMMED:    programmed_ff   <= csr_bus.data[0];
               REG_PAIRING_MODE:  pairing_mode_ff <= csr_bus.data[0];
               REG_TIMEOUT_TICKS: timeout_ff      <= csr_bus.data;
               REG_MAX_SENDS:     max_sends_ff    <= csr_bus.data[3:0];
               default: begin
               end
            endcase
         end
         if (req_fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload register, loaded on accept only
   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.tx_valid     = rsp_ff.tx_valid;
   assign rsp_bus.tx_dest      = rsp_ff.tx_dest;
   assign rsp_bus.tx_src       = rsp_ff.tx_src;
   assign rsp_bus.tx_op        = rsp_ff.tx_op;
   assign rsp_bus.tx_temp      = rsp_ff.tx_temp;
   assign rsp_bus.tx_batt      = rsp_ff.tx_batt;
   assign rsp_bus.go_sleep     = rsp_ff.go_sleep;
   assign rsp_bus.paired       = rsp_ff.paired;
   assign rsp_bus.learned_base = rsp_ff.learned_base;

   // an empty response register never blocks the request side
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid_ff |-> req_bus.ready)
      else $error("request stalled with empty response register");

   // a pairing result always carries the pairing reply packet
   a_pair_reply: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.paired) |-> (rsp_ff.tx_valid && rsp_ff.tx_op == OP_PAIR_REPLY))
      else $error("pairing result without pairing reply");

   // a programmed start in normal mode with a nonzero limit sends data
   a_start_sends: assert property (@(posedge clock) disable iff (reset)
      (req_fire && cmd == CMD_START && !pairing_mode_ff && programmed_ff &&
       max_sends_ff != 4'd0) |=> (rsp_valid_ff && rsp_ff.tx_valid && !rsp_ff.go_sleep))
      else $error("start did not send a data packet");

endmodule
